### sv/fcr_pkg.sv
// Shared types and constants for the filled circle rasterizer.
// Depends on nothing; every other file imports it.
package fcr_pkg;

  // Radius field width after masking; offsets carry one sign bit more.
  localparam int RADIUS_BITS = 11;
  localparam int OFS_W       = RADIUS_BITS + 1;
  localparam int SQ_W        = 2 * RADIUS_BITS;
  localparam int CTR_W       = 16;
  localparam int POS_W       = ((OFS_W > CTR_W) ? OFS_W : CTR_W) + 1;

  localparam int SCR_W       = 13;
  localparam int PAN_W       = 12;
  localparam int BPP_W       = 3;
  localparam int STRIDE_W    = 16;
  localparam int ADDR_W      = 32;
  localparam int COLOR_W     = 8;

  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_W   = 3;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SCREEN_WIDTH    = 3'd0,
    REG_SCREEN_HEIGHT   = 3'd1,
    REG_PAN_X           = 3'd2,
    REG_PAN_Y           = 3'd3,
    REG_BYTES_PER_PIXEL = 3'd4,
    REG_LINE_STRIDE     = 3'd5
  } reg_idx_t;

  localparam logic [SCR_W-1:0]    RST_SCREEN_WIDTH    = 13'd640;
  localparam logic [SCR_W-1:0]    RST_SCREEN_HEIGHT   = 13'd480;
  localparam logic [PAN_W-1:0]    RST_PAN_X           = 12'd0;
  localparam logic [PAN_W-1:0]    RST_PAN_Y           = 12'd0;
  localparam logic [BPP_W-1:0]    RST_BYTES_PER_PIXEL = 3'd4;
  localparam logic [STRIDE_W-1:0] RST_LINE_STRIDE     = 16'd2560;

  typedef struct packed {
    logic [SCR_W-1:0]    screen_width;
    logic [SCR_W-1:0]    screen_height;
    logic [PAN_W-1:0]    pan_x;
    logic [PAN_W-1:0]    pan_y;
    logic [BPP_W-1:0]    bytes_per_pixel;
    logic [STRIDE_W-1:0] line_stride;
  } cfg_t;

  typedef struct packed {
    logic                    func;
    logic signed [CTR_W-1:0] centre_x;
    logic signed [CTR_W-1:0] centre_y;
    logic [10:0]             radius;
    logic [COLOR_W-1:0]      red;
    logic [COLOR_W-1:0]      green;
    logic [COLOR_W-1:0]      blue;
  } in_word_t;

  typedef struct packed {
    logic               write_enable;
    logic [ADDR_W-1:0]  write_address;
    logic [COLOR_W-1:0] out_blue;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_red;
    logic               done_res;
  } out_word_t;

endpackage

### sv/filled_circle_rasterizer_core.sv
// Top level of the filled circle rasterizer.
// Depends on fcr_pkg, fcr_cfg_regs, fcr_in_stage and fcr_scan_core.
//
// Usage:
//   Input channel (in_valid / in_ready / in_data): each word is either a
//   start (func = 0) carrying centre, radius and colour, or a step
//   (func = 1) that visits one point of the square -r..r-1 by -r..r-1,
//   row by row. Every input word yields exactly one result word.
//   Result channel (out_valid / out_ready / out_data): write_enable marks a
//   framebuffer write of blue, green, red at write_address; done_res marks
//   the word that completes the circle (or a start with radius zero).
//   Configuration: APB-style port; write only while no words are in flight.
// Timing:
//   One word per clock sustained while out_ready stays high. A word is held
//   in the input register, then the circle test, clip and address build run
//   combinationally into the result register. The row address term (one
//   16-bit multiply) sets the cycle's depth.
// Reset (rst_n low, synchronous): scan idle, both stages empty, registers at
//   their defaults (640 x 480, no pan, 4 bytes per pixel, stride 2560).
// Stall: when out_ready is low the result register holds its word; the input
//   register still takes one more word, then in_ready drops until space frees.
module filled_circle_rasterizer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fcr_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fcr_pkg::out_word_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcr_pkg::PADDR_W-1:0] paddr,
  input  logic [fcr_pkg::PDATA_W-1:0] pwdata,
  output logic [fcr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import fcr_pkg::*;

  cfg_t     cfg;
  logic     item_valid;
  logic     item_ready;
  in_word_t item;

  // Register file; values feed the clip and address logic directly.
  fcr_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Hold the incoming word until the scan core takes it.
  fcr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  // Advance the scan, test the point and register the result word.
  fcr_scan_core u_scan_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### sv/fcr_cfg_regs.sv
// Configuration register file behind the APB-style port.
// Depends on fcr_pkg for the register map and the cfg_t struct.
module fcr_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fcr_pkg::PADDR_W-1:0] paddr,
  input  logic [fcr_pkg::PDATA_W-1:0] pwdata,
  output logic [fcr_pkg::PDATA_W-1:0] prdata,
  output logic                      pready,
  output fcr_pkg::cfg_t             cfg
);
  import fcr_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx_t'(reg_idx))
        REG_SCREEN_WIDTH:    cfg_nxt.screen_width    = pwdata[SCR_W-1:0];
        REG_SCREEN_HEIGHT:   cfg_nxt.screen_height   = pwdata[SCR_W-1:0];
        REG_PAN_X:           cfg_nxt.pan_x           = pwdata[PAN_W-1:0];
        REG_PAN_Y:           cfg_nxt.pan_y           = pwdata[PAN_W-1:0];
        REG_BYTES_PER_PIXEL: cfg_nxt.bytes_per_pixel = pwdata[BPP_W-1:0];
        REG_LINE_STRIDE:     cfg_nxt.line_stride     = pwdata[STRIDE_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(reg_idx))
      REG_SCREEN_WIDTH:    prdata = PDATA_W'(cfg_r.screen_width);
      REG_SCREEN_HEIGHT:   prdata = PDATA_W'(cfg_r.screen_height);
      REG_PAN_X:           prdata = PDATA_W'(cfg_r.pan_x);
      REG_PAN_Y:           prdata = PDATA_W'(cfg_r.pan_y);
      REG_BYTES_PER_PIXEL: prdata = PDATA_W'(cfg_r.bytes_per_pixel);
      REG_LINE_STRIDE:     prdata = PDATA_W'(cfg_r.line_stride);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width    <= RST_SCREEN_WIDTH;
      cfg_r.screen_height   <= RST_SCREEN_HEIGHT;
      cfg_r.pan_x           <= RST_PAN_X;
      cfg_r.pan_y           <= RST_PAN_Y;
      cfg_r.bytes_per_pixel <= RST_BYTES_PER_PIXEL;
      cfg_r.line_stride     <= RST_LINE_STRIDE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/fcr_in_stage.sv
// Input register stage: captures one input word and offers it to the scan core.
// Depends on fcr_pkg for the in_word_t struct.
module fcr_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fcr_pkg::in_word_t in_data,
  output logic              item_valid,
  input  logic              item_ready,
  output fcr_pkg::in_word_t item
);
  import fcr_pkg::*;

  logic     in_valid_r;
  logic     in_valid_nxt;
  in_word_t in_data_r;

  // Refill in the same cycle the held word moves on.
  assign in_ready = !in_valid_r || item_ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ready) begin
      in_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  assign item_valid = in_valid_r;
  assign item       = in_data_r;

endmodule

### sv/fcr_scan_core.sv
// Scan state, per-point circle and clip test, address build and result register.
// Depends on fcr_pkg for field widths, codes and the word structs.
module fcr_scan_core (
  input  logic               clk,
  input  logic               rst_n,
  input  fcr_pkg::cfg_t      cfg,
  input  logic               item_valid,
  output logic               item_ready,
  input  fcr_pkg::in_word_t  item,
  output logic               out_valid,
  input  logic               out_ready,
  output fcr_pkg::out_word_t out_data
);
  import fcr_pkg::*;

  // Scan state
  logic                    active_r,  active_nxt;
  logic signed [OFS_W-1:0] ofs_i_r,   ofs_i_nxt;
  logic signed [OFS_W-1:0] ofs_j_r,   ofs_j_nxt;
  logic signed [CTR_W-1:0] cx_r,      cx_nxt;
  logic signed [CTR_W-1:0] cy_r,      cy_nxt;
  logic [RADIUS_BITS-1:0]  rad_r,     rad_nxt;
  logic [COLOR_W-1:0]      blue_r,    blue_nxt;
  logic [COLOR_W-1:0]      green_r,   green_nxt;
  logic [COLOR_W-1:0]      red_r,     red_nxt;
  // Running squares of the offsets and the squared radius
  logic [SQ_W-1:0]         sq_i_r,    sq_i_nxt;
  logic [SQ_W-1:0]         sq_j_r,    sq_j_nxt;
  logic [SQ_W-1:0]         rsq_r,     rsq_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r;
  out_word_t res;

  logic                    take;
  logic [RADIUS_BITS-1:0]  r_in;
  logic signed [OFS_W-1:0] neg_r_in;
  logic signed [OFS_W-1:0] neg_r;
  logic signed [OFS_W-1:0] r_s;
  logic [SQ_W-1:0]         rsq_start;
  logic signed [OFS_W-1:0] i_inc;
  logic signed [OFS_W-1:0] j_inc;
  logic signed [SQ_W+1:0]  sq_i_wide;
  logic signed [SQ_W+1:0]  sq_j_wide;
  logic                    last_i;
  logic                    last_j;
  logic                    inside_c;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                    on_screen;
  logic [SCR_W:0]          xp;
  logic [SCR_W:0]          yp;
  logic [ADDR_W-1:0]       addr;

  assign item_ready = !out_valid_r || out_ready;
  assign take       = item_valid && item_ready;

  // Start values
  assign r_in      = RADIUS_BITS'(item.radius);
  assign neg_r_in  = -$signed({1'b0, r_in});
  assign rsq_start = SQ_W'(r_in) * SQ_W'(r_in);

  // Step position
  assign r_s    = $signed({1'b0, rad_r});
  assign neg_r  = -r_s;
  assign i_inc  = ofs_i_r + $signed(OFS_W'(1));
  assign j_inc  = ofs_j_r + $signed(OFS_W'(1));
  assign last_i = !(i_inc < r_s);
  assign last_j = !(j_inc < r_s);

  // (k+1)^2 = k^2 + 2k + 1
  assign sq_i_wide = $signed({2'b00, sq_i_r}) + (SQ_W+2)'($signed({ofs_i_r, 1'b1}));
  assign sq_j_wide = $signed({2'b00, sq_j_r}) + (SQ_W+2)'($signed({ofs_j_r, 1'b1}));

  assign inside_c = ({1'b0, sq_i_r} + {1'b0, sq_j_r}) < {1'b0, rsq_r};

  assign pos_x = POS_W'(cx_r) + POS_W'(ofs_i_r);
  assign pos_y = POS_W'(cy_r) + POS_W'(ofs_j_r);
  assign on_screen = !pos_x[POS_W-1] && !pos_y[POS_W-1] &&
                     (pos_x[POS_W-2:0] < (POS_W-1)'(cfg.screen_width)) &&
                     (pos_y[POS_W-2:0] < (POS_W-1)'(cfg.screen_height));

  // On screen means both coordinates fit in the screen field width.
  assign xp   = {1'b0, pos_x[SCR_W-1:0]} + (SCR_W+1)'(cfg.pan_x);
  assign yp   = {1'b0, pos_y[SCR_W-1:0]} + (SCR_W+1)'(cfg.pan_y);
  assign addr = ADDR_W'(xp) * ADDR_W'(cfg.bytes_per_pixel) +
                ADDR_W'(yp) * ADDR_W'(cfg.line_stride);

  always_comb begin
    active_nxt = active_r;
    ofs_i_nxt  = ofs_i_r;
    ofs_j_nxt  = ofs_j_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    rad_nxt    = rad_r;
    blue_nxt   = blue_r;
    green_nxt  = green_r;
    red_nxt    = red_r;
    sq_i_nxt   = sq_i_r;
    sq_j_nxt   = sq_j_r;
    rsq_nxt    = rsq_r;
    res        = '0;
    if (item.func == FUNC_START) begin
      cx_nxt        = $signed(item.centre_x);
      cy_nxt        = $signed(item.centre_y);
      rad_nxt       = r_in;
      blue_nxt      = item.blue;
      green_nxt     = item.green;
      red_nxt       = item.red;
      ofs_i_nxt     = neg_r_in;
      ofs_j_nxt     = neg_r_in;
      sq_i_nxt      = rsq_start;
      sq_j_nxt      = rsq_start;
      rsq_nxt       = rsq_start;
      active_nxt    = (r_in != '0);
      res.done_res  = (r_in == '0);
    end else if (active_r) begin
      if (inside_c && on_screen) begin
        res.write_enable  = 1'b1;
        res.write_address = addr;
        res.out_blue      = blue_r;
        res.out_green     = green_r;
        res.out_red       = red_r;
      end
      if (!last_i) begin
        ofs_i_nxt = i_inc;
        sq_i_nxt  = sq_i_wide[SQ_W-1:0];
      end else if (!last_j) begin
        ofs_i_nxt = neg_r;
        sq_i_nxt  = rsq_r;
        ofs_j_nxt = j_inc;
        sq_j_nxt  = sq_j_wide[SQ_W-1:0];
      end else begin
        active_nxt   = 1'b0;
        res.done_res = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      ofs_i_r     <= '0;
      ofs_j_r     <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      rad_r       <= '0;
      blue_r      <= '0;
      green_r     <= '0;
      red_r       <= '0;
      sq_i_r      <= '0;
      sq_j_r      <= '0;
      rsq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        active_r <= active_nxt;
        ofs_i_r  <= ofs_i_nxt;
        ofs_j_r  <= ofs_j_nxt;
        cx_r     <= cx_nxt;
        cy_r     <= cy_nxt;
        rad_r    <= rad_nxt;
        blue_r   <= blue_nxt;
        green_r  <= green_nxt;
        red_r    <= red_nxt;
        sq_i_r   <= sq_i_nxt;
        sq_j_r   <= sq_j_nxt;
        rsq_r    <= rsq_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_ofs_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (ofs_i_r < r_s) && (ofs_j_r < r_s))
    else $error("scan offset beyond radius");

  a_sq_tracks_i: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> ((SQ_W+2)'(ofs_i_r) * (SQ_W+2)'(ofs_i_r)) == (SQ_W+2)'(sq_i_r))
    else $error("running square of column offset out of step");

  a_sq_tracks_j: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> ((SQ_W+2)'(ofs_j_r) * (SQ_W+2)'(ofs_j_r)) == (SQ_W+2)'(sq_j_r))
    else $error("running square of row offset out of step");

  a_last_point_idles: assert property (@(posedge clk) disable iff (!rst_n)
    take && (item.func == FUNC_STEP) && active_r && last_i && last_j
    |=> !active_r && out_valid_r && out_data_r.done_res)
    else $error("last scan point did not finish the circle");

  a_zero_radius_done: assert property (@(posedge clk) disable iff (!rst_n)
    take && (item.func == FUNC_START) && (r_in == '0)
    |=> !active_r && out_valid_r && out_data_r.done_res && !out_data_r.write_enable)
    else $error("zero radius start not done at once");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for filled_circle_rasterizer_core: scan circles and compare writes.
// Depends on fcr_pkg and the RTL top level; it holds its own predictor of the scan.
module tb;
  import fcr_pkg::*;

  localparam int IDLE_LIMIT = 2000;  // cycles with work pending but no word moving
  localparam int PHASE_ITEMS = 130;  // counted words per random phase
  localparam int NUM_PHASES = 6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  filled_circle_rasterizer_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 8 ns period: low half, then high half.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Words waiting to be sent, and the pixel results they are predicted to give.
  in_word_t words_to_send[$];
  out_word_t pixel_results_due[$];
  out_word_t due_word;
  int error_count = 0;
  int result_count = 0;

  // Shadow of the register file, kept in step with every bus write.
  logic [SCR_W-1:0] scr_w = RST_SCREEN_WIDTH;
  logic [SCR_W-1:0] scr_h = RST_SCREEN_HEIGHT;
  logic [PAN_W-1:0] pan_x_q = RST_PAN_X;
  logic [PAN_W-1:0] pan_y_q = RST_PAN_Y;
  logic [BPP_W-1:0] bpp_q = RST_BYTES_PER_PIXEL;
  logic [STRIDE_W-1:0] stride_q = RST_LINE_STRIDE;

  // Scan state of the predictor: current offsets and the latched circle.
  logic scan_on = 1'b0;
  int ofs_i = 0;
  int ofs_j = 0;
  int ctr_x = 0;
  int ctr_y = 0;
  int rad = 0;
  logic [23:0] fill_rgb = '0;

  // Compute the result word that one input word gives, and advance the scan.
  function automatic out_word_t rasterize_word(in_word_t w);
    out_word_t res;
    int px;
    int py;
    logic [31:0] col_term;
    logic [31:0] row_term;
    res = '0;
    if (w.func == FUNC_START) begin
      // Latch the circle and arm the scan at the top-left corner of its box.
      ctr_x = $signed(w.centre_x);
      ctr_y = $signed(w.centre_y);
      rad = int'(w.radius) & ((1 << RADIUS_BITS) - 1);
      fill_rgb = {w.red, w.green, w.blue};
      ofs_i = -rad;
      ofs_j = -rad;
      // A zero radius completes at once and leaves the scan idle.
      scan_on = (rad != 0);
      res.done_res = (rad == 0);
    end else if (scan_on) begin
      px = ctr_x + ofs_i;
      py = ctr_y + ofs_j;
      // Write only inside the circle and only on the visible screen.
      if (ofs_i * ofs_i + ofs_j * ofs_j < rad * rad && px >= 0 && py >= 0 &&
          px < int'(scr_w) && py < int'(scr_h)) begin
        col_term = 32'(px) + 32'(pan_x_q);
        row_term = 32'(py) + 32'(pan_y_q);
        res.write_enable = 1'b1;
        res.write_address = col_term * bpp_q + row_term * stride_q;
        res.out_blue = fill_rgb[7:0];
        res.out_green = fill_rgb[15:8];
        res.out_red = fill_rgb[23:16];
      end
      // Advance along the row, wrap to the next row, or finish on the last point.
      if (ofs_i + 1 < rad) begin
        ofs_i = ofs_i + 1;
      end else if (ofs_j + 1 < rad) begin
        ofs_i = -rad;
        ofs_j = ofs_j + 1;
      end else begin
        scan_on = 1'b0;
        res.done_res = 1'b1;
      end
    end
    // A step while idle gives an all-zero result.
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("mismatch in %s at result %0d: got %h, want %h", field, result_count, got,
             want);
  endtask

  // Register write: setup cycle, then access cycle; keep the shadow in step.
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH:    scr_w = val[SCR_W-1:0];
      REG_SCREEN_HEIGHT:   scr_h = val[SCR_W-1:0];
      REG_PAN_X:           pan_x_q = val[PAN_W-1:0];
      REG_PAN_Y:           pan_y_q = val[PAN_W-1:0];
      REG_BYTES_PER_PIXEL: bpp_q = val[BPP_W-1:0];
      REG_LINE_STRIDE:     stride_q = val[STRIDE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input int w, input int h, input int px, input int py,
                              input int bpp, input int stride);
    cfg_write(REG_SCREEN_WIDTH, w);
    cfg_write(REG_SCREEN_HEIGHT, h);
    cfg_write(REG_PAN_X, px);
    cfg_write(REG_PAN_Y, py);
    cfg_write(REG_BYTES_PER_PIXEL, bpp);
    cfg_write(REG_LINE_STRIDE, stride);
  endtask

  function automatic in_word_t start_word(input int cx, input int cy, input int r,
                                          input int red, input int green, input int blue);
    in_word_t w;
    w.func = FUNC_START;
    w.centre_x = cx[15:0];
    w.centre_y = cy[15:0];
    w.radius = r[10:0];
    w.red = red[7:0];
    w.green = green[7:0];
    w.blue = blue[7:0];
    return w;
  endfunction

  // Step words carry random junk in the fields that a step ignores.
  function automatic in_word_t step_word();
    in_word_t w;
    w.func = FUNC_STEP;
    w.centre_x = 16'($urandom);
    w.centre_y = 16'($urandom);
    w.radius = 11'($urandom);
    w.red = 8'($urandom);
    w.green = 8'($urandom);
    w.blue = 8'($urandom);
    return w;
  endfunction

  // Place a centre near the origin, near the far edge, or anywhere at all.
  function automatic int pick_centre(input int r, input int scr);
    int v;
    case ($urandom_range(0, 3))
      0, 1: v = int'($urandom_range(0, r + 12)) - r - 2;
      2: v = scr - r - 2 + int'($urandom_range(0, 2 * r + 4));
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return v;
  endfunction

  // Queue one circle: mostly complete small scans, some cut short by the next start.
  // The counted steps never run past the words left in the phase budget.
  task automatic add_circle(input int budget, output int counted);
    int r;
    int steps;
    case ($urandom_range(0, 19))
      0: r = $urandom_range(0, 2047);
      1: r = 0;
      2, 3: r = $urandom_range(7, 12);
      default: r = $urandom_range(1, 6);
    endcase
    words_to_send.push_back(start_word(pick_centre(r, int'(scr_w)),
                                       pick_centre(r, int'(scr_h)), r, $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 255)));
    steps = 4 * r * r;
    if (r > 12)
      steps = $urandom_range(0, 40);
    else if ($urandom_range(0, 7) == 0)
      steps = $urandom_range(0, steps);
    if (steps > budget - 1)
      steps = budget - 1;
    for (int k = 0; k < steps; k++)
      words_to_send.push_back(step_word());
    counted = 1 + steps;
    // Throw in a few more steps; past the end of the scan they do nothing.
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) words_to_send.push_back(step_word());
    end
  endtask

  task automatic wait_drained();
    while (words_to_send.size() != 0 || pixel_results_due.size() != 0) @(posedge clk);
  endtask

  // Sender: bursts of random length, random gaps between them, some long clean runs.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      // Predict the result of the word that moves at this edge.
      if (in_valid && in_ready)
        pixel_results_due.push_back(rasterize_word(words_to_send.pop_front()));
      // Hold the word until it moves; then load the next one or idle.
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= words_to_send[0];
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: out_ready follows a rotating 16-bit pattern, reloaded at random when pat_age wraps.
  logic [15:0] ready_pat = 16'hffff;
  int pat_age = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_results_due.size() == 0) begin
          report_mismatch("unexpected result", out_data.write_address, '0);
        end else begin
          due_word = pixel_results_due.pop_front();
          if (out_data.write_enable !== due_word.write_enable)
            report_mismatch("write_enable", 32'(out_data.write_enable),
                            32'(due_word.write_enable));
          if (out_data.write_address !== due_word.write_address)
            report_mismatch("write_address", out_data.write_address, due_word.write_address);
          if (out_data.out_blue !== due_word.out_blue)
            report_mismatch("out_blue", 32'(out_data.out_blue), 32'(due_word.out_blue));
          if (out_data.out_green !== due_word.out_green)
            report_mismatch("out_green", 32'(out_data.out_green), 32'(due_word.out_green));
          if (out_data.out_red !== due_word.out_red)
            report_mismatch("out_red", 32'(out_data.out_red), 32'(due_word.out_red));
          if (out_data.done_res !== due_word.done_res)
            report_mismatch("done_res", 32'(out_data.done_res), 32'(due_word.done_res));
        end
        result_count++;
      end
      pat_age = pat_age + 1;
      if (pat_age == 64) begin
        pat_age = 0;
        case ($urandom_range(0, 3))
          0: ready_pat = 16'hffff;
          1: ready_pat = 16'($urandom) | 16'h0001;
          2: ready_pat = 16'h0101;
          default: ready_pat = 16'hf00f;
        endcase
      end
      out_ready <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[15:1]};
    end
  end

  // Watchdog: count cycles with work outstanding in which no word moves.
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (words_to_send.size() == 0 && pixel_results_due.size() == 0)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int counted;
    int phase_items;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words under the reset-time registers (640 x 480).
    words_to_send.push_back(step_word());                        // step while idle
    words_to_send.push_back(start_word(0, 0, 0, 255, 255, 255)); // zero radius: done at once
    words_to_send.push_back(step_word());
    words_to_send.push_back(start_word(0, 0, 1, 18, 52, 86));    // only the centre is inside
    repeat (4) words_to_send.push_back(step_word());
    words_to_send.push_back(start_word(639, 479, 1, 255, 0, 128)); // last visible pixel
    repeat (4) words_to_send.push_back(step_word());
    words_to_send.push_back(start_word(640, 480, 1, 1, 2, 3));   // just off screen
    repeat (4) words_to_send.push_back(step_word());
    // Field extremes; each scan is abandoned by the next start.
    words_to_send.push_back(start_word(-32768, 32767, 2047, 255, 255, 255));
    repeat (2) words_to_send.push_back(step_word());
    words_to_send.push_back(start_word(32767, -32768, 1024, 0, 0, 0));
    words_to_send.push_back(step_word());
    wait_drained();

    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      // Let the pipeline settle before touching the registers.
      repeat (4) @(posedge clk);
      case (phase)
        1: program_regs(1, 1, 0, 0, 1, 1);
        2: program_regs(8191, 8191, 4095, 4095, 7, 65535);
        3: program_regs(0, 4096, $urandom_range(0, 4095), $urandom_range(0, 4095), 0,
                        $urandom_range(1, 65535));
        4: program_regs($urandom_range(16, 96), $urandom_range(16, 96),
                        $urandom_range(0, 4095), $urandom_range(0, 4095), 3,
                        $urandom_range(1, 65535));
        5: program_regs(4096, 1, $urandom_range(0, 4095), 4095, $urandom_range(0, 7),
                        $urandom_range(0, 65535));
        default: program_regs(640, 480, 0, 0, 4, 2560);
      endcase
      @(negedge clk);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        add_circle(PHASE_ITEMS - phase_items, counted);
        phase_items += counted;
      end
      wait_drained();
    end

    // Allow a stray late result to show up before the verdict.
    repeat (16) @(posedge clk);
    if (error_count == 0 && pixel_results_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### filled_circle_rasterizer_core.f
sv/fcr_pkg.sv
sv/fcr_cfg_regs.sv
sv/fcr_in_stage.sv
sv/fcr_scan_core.sv
sv/filled_circle_rasterizer_core.sv
tb/tb.sv
